>>> sv/iprw_pkg.sv
package iprw_pkg;

  localparam int WORD_W    = 64;
  localparam int LANE_W    = 16;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int V4_GROUPS = 4;
  localparam int V4_BITS   = 8;
  localparam int LANES_PER_WORD = WORD_W / LANE_W;

  localparam logic [WORD_W-1:0] VOL_EXCLUDED = 64'd2;

  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEXT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IS_IPV6    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASKED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_UPPER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_LOWER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_UPPER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_LOWER   = 3'd5;

  typedef enum logic [2:0] {
    LANE_HOLD,
    LANE_LOAD,
    LANE_LOAD_INC,
    LANE_CLEAR,
    LANE_INC,
    LANE_RESET
  } lane_op_t;

  typedef struct packed {
    logic lt;
    logic nonempty;
    logic inverted;
    logic probe_ok;
    logic cur_eq;
    logic inc_eq;
  } lane_stat_t;

  typedef enum logic [2:0] {
    VOL_IDLE,
    VOL_LO,
    VOL_HI,
    VOL_ADD,
    VOL_FIN
  } vol_state_t;

endpackage

>>> sv/iprw_lane.sv
module iprw_lane #(
  parameter int IDX   = 0,
  parameter int GRP_W = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           is_ipv6,
  input  logic [iprw_pkg::LANE_W-1:0]    from_lane,
  input  logic [iprw_pkg::LANE_W-1:0]    to_lane,
  input  logic [iprw_pkg::LANE_W-1:0]    probe_lane,
  input  iprw_pkg::lane_op_t             op,
  output iprw_pkg::lane_stat_t           stat,
  output logic [GRP_W:0]                 cnt,
  output logic [iprw_pkg::LANE_W-1:0]    addr
);
  import iprw_pkg::*;

  logic [GRP_W-1:0]   cur;
  logic [GRP_W-1:0]   cur_next;
  logic [GRP_W-1:0]   f;
  logic [GRP_W-1:0]   t;
  logic [GRP_W:0]     cur_inc;
  logic [V4_BITS-1:0] from_inc;
  logic               active;

  assign active   = is_ipv6 || (IDX < V4_GROUPS);
  assign f        = is_ipv6 ? from_lane[GRP_W-1:0] : GRP_W'(from_lane[V4_BITS-1:0]);
  assign t        = is_ipv6 ? to_lane[GRP_W-1:0]   : GRP_W'(to_lane[V4_BITS-1:0]);
  assign cur_inc  = {1'b0, cur} + (GRP_W+1)'(1);
  assign from_inc = from_lane[V4_BITS-1:0] + V4_BITS'(1);
  assign cnt      = {1'b0, t} - {1'b0, f} + (GRP_W+1)'(1);

  assign stat.lt       = cur < t;
  assign stat.nonempty = f < t;
  assign stat.inverted = t < f;
  assign stat.probe_ok = (probe_lane >= LANE_W'(f)) && (probe_lane <= LANE_W'(t));
  assign stat.cur_eq   = cur == t;
  assign stat.inc_eq   = cur_inc == {1'b0, t};

  always_comb begin
    case (op)
      LANE_HOLD:     cur_next = cur;
      LANE_LOAD:     cur_next = f;
      LANE_LOAD_INC: cur_next = GRP_W'(from_inc);
      LANE_CLEAR:    cur_next = '0;
      LANE_INC:      cur_next = cur_inc[GRP_W-1:0];
      LANE_RESET:    cur_next = (f < t) ? f : cur;
      default:       cur_next = cur;
    endcase
  end

  assign addr = active ? LANE_W'(cur_next) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else begin
      cur <= cur_next;
    end
  end

endmodule

>>> sv/iprw_merge.sv
module iprw_merge #(
  parameter int MAX_GROUPS = 8
) (
  input  logic [iprw_pkg::KIND_W-1:0]               kind,
  input  logic                                      accept,
  input  logic                                      is_ipv6,
  input  logic                                      masked,
  input  iprw_pkg::lane_stat_t [MAX_GROUPS-1:0]     stat,
  output iprw_pkg::lane_op_t   [MAX_GROUPS-1:0]     op,
  output logic                                      more,
  output logic                                      in_range
);
  import iprw_pkg::*;

  logic v4m;

  assign v4m = !is_ipv6 && masked;

  always_comb begin
    logic found;
    logic all_eq;
    logic ok;
    logic active;
    found    = 1'b0;
    all_eq   = 1'b1;
    ok       = 1'b1;
    more     = 1'b0;
    in_range = 1'b0;
    for (int g = 0; g < MAX_GROUPS; g++) begin
      op[g] = LANE_HOLD;
    end
    if (accept) begin
      case (kind)
        KIND_RESTART: begin
          for (int g = 0; g < MAX_GROUPS; g++) begin
            active = is_ipv6 || (g < V4_GROUPS);
            if (!active) begin
              op[g] = LANE_CLEAR;
            end else if (v4m && (g == V4_GROUPS - 1)) begin
              op[g] = LANE_LOAD_INC;
            end else begin
              op[g] = LANE_LOAD;
            end
          end
          more = 1'b1;
        end
        KIND_NEXT: begin
          for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
            active = is_ipv6 || (g < V4_GROUPS);
            if (active) begin
              if (found) begin
                all_eq = all_eq && stat[g].cur_eq;
              end else if (stat[g].lt) begin
                op[g]  = LANE_INC;
                found  = 1'b1;
                all_eq = all_eq && stat[g].inc_eq;
              end else begin
                op[g]  = LANE_RESET;
                all_eq = all_eq && !stat[g].nonempty && stat[g].cur_eq;
              end
            end
          end
          more = found && !(v4m && all_eq);
        end
        KIND_CHECK: begin
          for (int g = 0; g < MAX_GROUPS; g++) begin
            active = is_ipv6 || (g < V4_GROUPS);
            if (active) begin
              ok = ok && stat[g].probe_ok;
            end
          end
          in_range = ok;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> sv/iprw_volume.sv
module iprw_volume #(
  parameter int MAX_GROUPS = 8,
  parameter int GRP_W      = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   is_ipv6,
  input  logic                                   masked,
  input  logic [MAX_GROUPS-1:0][GRP_W:0]         cnt,
  input  logic [MAX_GROUPS-1:0]                  inverted,
  output logic                                   busy,
  output logic [iprw_pkg::WORD_W-1:0]            volume
);
  import iprw_pkg::*;

  localparam int GW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int HALF = WORD_W / 2;
  localparam int PW   = HALF + GRP_W + 1;
  localparam int SUMW = WORD_W + GRP_W + 2;

  vol_state_t state;
  vol_state_t state_next;

  logic [GW-1:0]         gidx;
  logic [GW-1:0]         last;
  logic [WORD_W-1:0]     acc;
  logic                  sat;
  logic [PW-1:0]         plo;
  logic [PW-1:0]         phi;
  logic [HALF-1:0]       mul_a;
  logic [PW-1:0]         prod;
  logic [SUMW-1:0]       sum;
  logic                  ovf;
  logic [MAX_GROUPS-1:0] active_mask;
  logic                  any_inv;

  always_comb begin
    for (int g = 0; g < MAX_GROUPS; g++) begin
      active_mask[g] = is_ipv6 || (g < V4_GROUPS);
    end
  end

  assign any_inv = |(inverted & active_mask);
  assign last    = is_ipv6 ? GW'(MAX_GROUPS - 1) : GW'(V4_GROUPS - 1);
  assign mul_a   = (state == VOL_HI) ? acc[WORD_W-1:HALF] : acc[HALF-1:0];
  assign prod    = PW'(mul_a) * PW'(cnt[gidx]);
  assign sum     = {1'b0, phi, {HALF{1'b0}}} + {{(SUMW-PW){1'b0}}, plo};
  assign ovf     = |sum[SUMW-1:WORD_W];
  assign busy    = state != VOL_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      VOL_IDLE: state_next = VOL_IDLE;
      VOL_LO:   state_next = VOL_HI;
      VOL_HI:   state_next = VOL_ADD;
      VOL_ADD:  state_next = (gidx == last) ? VOL_FIN : VOL_LO;
      VOL_FIN:  state_next = VOL_IDLE;
      default:  state_next = VOL_IDLE;
    endcase
    if (start) begin
      state_next = VOL_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= VOL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= WORD_W'(1);
      acc    <= WORD_W'(1);
      sat    <= 1'b0;
      gidx   <= '0;
    end else if (start) begin
      acc  <= WORD_W'(1);
      sat  <= 1'b0;
      gidx <= '0;
    end else begin
      case (state)
        VOL_LO: plo <= prod;
        VOL_HI: phi <= prod;
        VOL_ADD: begin
          if (!sat) begin
            if (ovf) begin
              sat <= 1'b1;
            end else begin
              acc <= sum[WORD_W-1:0];
            end
          end
          gidx <= gidx + GW'(1);
        end
        VOL_FIN: begin
          if (any_inv) begin
            volume <= '0;
          end else if (sat) begin
            volume <= '1;
          end else if (!is_ipv6 && masked) begin
            volume <= (acc >= VOL_EXCLUDED) ? acc - VOL_EXCLUDED : '0;
          end else begin
            volume <= acc;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> sv/ip_range_address_walker.sv
// Walks an IP address range group by group, one lane per group. Each item
// (restart, next or check) is answered by a registered result: the lanes
// compare the current group values against their bounds and the merge
// stage picks the odometer carry position, so the block takes one item per
// cycle while the result register drains and the volume is not busy. The
// range volume depends on configuration only; after each configuration
// write a shared 32 x (GRP_W+1) multiplier recomputes it (low product, high
// product and add per active group, then a final step); input is held off.
module ip_range_address_walker #(
  parameter int MAX_GROUPS = 8,
  parameter int GRP_W      = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [iprw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iprw_pkg::WORD_W-1:0]         cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // probe_upper[63:0], probe_lower[127:64]
  input  logic [127:0]                        s_axis_tdata,
  // kind[1:0]
  input  logic [iprw_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // address_upper[63:0], address_lower[127:64], more[128], in_range[129],
  // volume[193:130], zero[199:194]
  output logic [199:0]                        m_axis_tdata
);
  import iprw_pkg::*;

  logic              is_ipv6;
  logic              masked;
  logic [WORD_W-1:0] from_upper;
  logic [WORD_W-1:0] from_lower;
  logic [WORD_W-1:0] to_upper;
  logic [WORD_W-1:0] to_lower;

  logic cfg_accept;
  logic accept;
  logic vol_busy;
  logic more;
  logic in_range;

  logic [WORD_W-1:0]                  volume;
  lane_stat_t [MAX_GROUPS-1:0]        stat;
  lane_op_t   [MAX_GROUPS-1:0]        op;
  logic [MAX_GROUPS-1:0][GRP_W:0]     cnt;
  logic [MAX_GROUPS-1:0]              inverted;
  logic [2*LANES_PER_WORD-1:0][LANE_W-1:0] addr;
  logic [WORD_W-1:0]                  addr_upper;
  logic [WORD_W-1:0]                  addr_lower;

  assign cfg_ready     = 1'b1;
  assign cfg_accept    = cfg_valid && cfg_ready;
  assign s_axis_tready = !vol_busy && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_ipv6    <= 1'b0;
      masked     <= 1'b0;
      from_upper <= '0;
      from_lower <= '0;
      to_upper   <= '0;
      to_lower   <= '0;
    end else if (cfg_accept) begin
      case (cfg_index)
        CFG_IS_IPV6:    is_ipv6    <= cfg_data[0];
        CFG_MASKED:     masked     <= cfg_data[0];
        CFG_FROM_UPPER: from_upper <= cfg_data;
        CFG_FROM_LOWER: from_lower <= cfg_data;
        CFG_TO_UPPER:   to_upper   <= cfg_data;
        CFG_TO_LOWER:   to_lower   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < 2 * LANES_PER_WORD; g++) begin : g_lane
    localparam int SH = WORD_W - LANE_W * (g % LANES_PER_WORD + 1);
    if (g < MAX_GROUPS) begin : g_used
      logic [LANE_W-1:0] from_lane;
      logic [LANE_W-1:0] to_lane;
      logic [LANE_W-1:0] probe_lane;
      if (g < LANES_PER_WORD) begin : g_up
        assign from_lane  = from_upper[SH +: LANE_W];
        assign to_lane    = to_upper[SH +: LANE_W];
        assign probe_lane = s_axis_tdata[SH +: LANE_W];
      end else begin : g_lo
        assign from_lane  = from_lower[SH +: LANE_W];
        assign to_lane    = to_lower[SH +: LANE_W];
        assign probe_lane = s_axis_tdata[WORD_W + SH +: LANE_W];
      end
      iprw_lane #(
        .IDX   (g),
        .GRP_W (GRP_W)
      ) u_lane (
        .clk        (clk),
        .rst        (rst),
        .is_ipv6    (is_ipv6),
        .from_lane  (from_lane),
        .to_lane    (to_lane),
        .probe_lane (probe_lane),
        .op         (op[g]),
        .stat       (stat[g]),
        .cnt        (cnt[g]),
        .addr       (addr[g])
      );
      assign inverted[g] = stat[g].inverted;
    end else begin : g_unused
      assign addr[g] = '0;
    end
    if (g < LANES_PER_WORD) begin : g_pack_up
      assign addr_upper[SH +: LANE_W] = addr[g];
    end else begin : g_pack_lo
      assign addr_lower[SH +: LANE_W] = addr[g];
    end
  end

  iprw_merge #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_merge (
    .kind     (s_axis_tuser),
    .accept   (accept),
    .is_ipv6  (is_ipv6),
    .masked   (masked),
    .stat     (stat),
    .op       (op),
    .more     (more),
    .in_range (in_range)
  );

  iprw_volume #(
    .MAX_GROUPS (MAX_GROUPS),
    .GRP_W      (GRP_W)
  ) u_volume (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_accept),
    .is_ipv6  (is_ipv6),
    .masked   (masked),
    .cnt      (cnt),
    .inverted (inverted),
    .busy     (vol_busy),
    .volume   (volume)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {6'd0, volume, in_range, more, addr_lower, addr_upper};
    end
  end

endmodule
